// File: hw/rtl/fjp_pkg.sv
package fjp_pkg;

    localparam int DEF_CHAR_STORE_SIZE = 4096;
    localparam int DEF_MEMBER_LIMIT    = 64;
    localparam logic [7:0] DEF_MAX_WS_RUN = 8'd100;

    // parse phases
    typedef enum logic [3:0] {
        PH_OPEN,
        PH_FIRST,
        PH_KEYSTART,
        PH_KEY,
        PH_COLON,
        PH_VALSTART,
        PH_STR,
        PH_NUM,
        PH_LIT,
        PH_AFTER,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef enum logic [1:0] {
        K_WRITE  = 2'd0,
        K_MEMBER = 2'd1,
        K_EMPTY  = 2'd2,
        K_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        E_WHITESPACE = 4'd0,
        E_END        = 4'd1,
        E_NO_BRACE   = 4'd2,
        E_KEY_QUOTE  = 4'd3,
        E_COLON      = 4'd4,
        E_VAL_START  = 4'd5,
        E_LITERAL    = 4'd6,
        E_NESTED     = 4'd7,
        E_NUM_BIG    = 4'd8,
        E_STRUCT     = 4'd9,
        E_MEMBERS    = 4'd10,
        E_STORE_FULL = 4'd11,
        E_NO_ROOM    = 4'd12
    } t_err;

    typedef enum logic [1:0] {
        VT_STRING = 2'd0,
        VT_BOOL   = 2'd1,
        VT_NUMBER = 2'd2,
        VT_NULL   = 2'd3
    } t_vtype;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam logic [7:0] REG_ADDR_WS = 8'd0;

    // expected character of a literal after its first letter
    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [1:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            LIT_TRUE: begin
                case (p)
                    2'd0:    c = "r";
                    2'd1:    c = "u";
                    2'd2:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                case (p)
                    2'd0:    c = "a";
                    2'd1:    c = "l";
                    2'd2:    c = "s";
                    default: c = "e";
                endcase
            end
            default: begin
                case (p)
                    2'd0:    c = "u";
                    2'd1:    c = "l";
                    2'd2:    c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    // remaining letters after the first one
    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == LIT_FALSE) ? 3'd4 : 3'd3;
    endfunction

endpackage

// File: hw/rtl/fjp_if.sv
interface fjp_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] text_byte;

    modport source (output valid, output start_req, output text_byte, input ready);
    modport sink   (input valid, input start_req, input text_byte, output ready);
endinterface

interface fjp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] store_address;
    logic [7:0]  store_byte;
    logic [5:0]  member_index;
    logic [11:0] key_offset;
    logic [1:0]  val_type;
    logic [63:0] member_value;
    logic        is_final;
    logic [3:0]  error_code;

    modport source (
        output valid, output kind, output store_address, output store_byte,
        output member_index, output key_offset, output val_type,
        output member_value, output is_final, output error_code,
        input ready
    );
    modport sink (
        input valid, input kind, input store_address, input store_byte,
        input member_index, input key_offset, input val_type,
        input member_value, input is_final, input error_code,
        output ready
    );
endinterface

// File: hw/rtl/flat_json_object_parser.sv
// Flat JSON object parser.
// Input channel i_in: one text byte per transfer, with start_req to begin a
// new document (clears parse and character-store state before that byte).
// Output channel o_out: at most one result per byte - a character store
// write, a member record, an empty-object notice or a numbered error.
// Latency: a result is presented in the cycle after its byte is taken.
// Throughput: one byte per cycle; the per-byte step is a single pass of
// logic between the parse state registers and the output register, with
// the multiply-by-ten of number digits as its longest path.
// Stalls: the output register holds a result until it is taken; input
// ready stays high while that register is empty or being emptied, so a
// stalled receiver stops the input only while a result is waiting.
// Reset (i_rst_n low, synchronous): parser waits for the opening brace,
// store and counters are cleared, the whitespace limit register is 100.
// Config: APB write of register 0 (byte address 0) sets the whitespace
// limit; a value of zero acts as one. Write only while idle.
module flat_json_object_parser
    import fjp_pkg::*;
#(
    parameter int CHAR_STORE_SIZE = DEF_CHAR_STORE_SIZE,
    parameter int MEMBER_LIMIT    = DEF_MEMBER_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fjp_in_if.sink      i_in,
    fjp_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(CHAR_STORE_SIZE);
    localparam int CW = AW + 1;
    localparam int MW = $clog2(MEMBER_LIMIT);
    localparam logic [CW-1:0] STORE_LAST = CW'(CHAR_STORE_SIZE - 1);
    localparam logic [CW-1:0] STORE_SIZE = CW'(CHAR_STORE_SIZE);
    localparam logic [MW:0]   CNT_LIMIT  = (MW + 1)'(MEMBER_LIMIT - 1);

    // configuration register
    logic [7:0] r_ws_max;
    logic [7:0] ws_limit;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ADDR_WS[2]) ? {24'd0, r_ws_max} : 32'd0;
    assign ws_limit = (r_ws_max == 8'd0) ? 8'd1 : r_ws_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws_max <= DEF_MAX_WS_RUN;
        end else if (psel && penable && pwrite && paddr[2] == REG_ADDR_WS[2]) begin
            r_ws_max <= pwdata[7:0];
        end
    end

    // parse state
    t_phase          r_phase,     n_phase,     s_phase;
    logic [7:0]      r_ws,        n_ws,        s_ws;
    logic [AW-1:0]   r_next,      n_next,      s_next;
    logic            r_full,      n_full,      s_full;
    logic [AW-1:0]   r_start,     n_start,     s_start;
    logic [CW-1:0]   r_cur,       n_cur,       s_cur;
    logic            r_noroom,    n_noroom,    s_noroom;
    logic [MW-1:0]   r_count,     n_count,     s_count;
    logic [AW-1:0]   r_key,       n_key,       s_key;
    logic [63:0]     r_acc,       n_acc,       s_acc;
    logic            r_ovf,       n_ovf,       s_ovf;
    logic [1:0]      r_held,      n_held,      s_held;
    logic [2:0]      r_lpos,      n_lpos,      s_lpos;
    logic [1:0]      r_lkind,     n_lkind,     s_lkind;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_kind,  n_kind;
    logic [11:0] r_addr,  n_addr;
    logic [7:0]  r_byte,  n_byte;
    logic [5:0]  r_midx,  n_midx;
    logic [11:0] r_koff,  n_koff;
    logic [1:0]  r_vtype, n_vtype;
    logic [63:0] r_val,   n_val;
    logic        r_final, n_final;
    logic [3:0]  r_ecode, n_ecode;

    // step flags between the next-state and output blocks
    logic        res_has;
    t_kind       res_kind;
    t_err        err_code;
    logic        mem_final;
    logic [CW-1:0] wr_addr;
    logic [7:0]  wr_byte;

    logic        accept;
    logic [7:0]  b;
    logic        is_sp, is_digit, need_sp, go, err_hit;
    logic [7:0]  ws_base, ws_inc;
    logic [67:0] acc_x10;
    logic [CW-1:0] cur_inc;
    logic [MW:0] cnt_inc;
    logic [7:0]  lit_exp;
    logic [1:0]  lit_p;
    logic [2:0]  lpos_inc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.text_byte;

    // state seen by this byte: start_req clears it first
    always_comb begin
        if (i_in.start_req) begin
            s_phase = PH_OPEN;   s_ws = '0;     s_next = '0;   s_full = 1'b0;
            s_start = '0;        s_cur = '0;    s_noroom = 1'b0;
            s_count = '0;        s_key = '0;    s_acc = '0;    s_ovf = 1'b0;
            s_held = '0;         s_lpos = '0;   s_lkind = '0;
        end else begin
            s_phase = r_phase;   s_ws = r_ws;   s_next = r_next; s_full = r_full;
            s_start = r_start;   s_cur = r_cur; s_noroom = r_noroom;
            s_count = r_count;   s_key = r_key; s_acc = r_acc;   s_ovf = r_ovf;
            s_held = r_held;     s_lpos = r_lpos; s_lkind = r_lkind;
        end
    end

    assign is_sp    = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    assign acc_x10  = {1'b0, s_acc, 3'b000} + {3'b000, s_acc, 1'b0} + {60'd0, b - 8'h30};
    assign cur_inc  = s_cur + CW'(1);
    assign cnt_inc  = {1'b0, s_count} + (MW + 1)'(1);
    assign lit_p    = s_lpos[1:0];
    assign lit_exp  = lit_char(s_lkind, lit_p);
    assign lpos_inc = {1'b0, lit_p} + 3'd1;

    // next state and result selection
    always_comb begin
        n_phase = s_phase;  n_ws = s_ws;     n_next = s_next;   n_full = s_full;
        n_start = s_start;  n_cur = s_cur;   n_noroom = s_noroom;
        n_count = s_count;  n_key = s_key;   n_acc = s_acc;     n_ovf = s_ovf;
        n_held = s_held;    n_lpos = s_lpos; n_lkind = s_lkind;
        res_has = 1'b0;     res_kind = K_WRITE;  err_code = E_WHITESPACE;
        mem_final = 1'b0;   wr_addr = '0;    wr_byte = '0;
        err_hit = 1'b0;     go = 1'b0;
        is_digit = b inside {["0":"9"]};

        // end of a number is checked ahead of the whitespace handling
        need_sp = 1'b0;
        ws_base = s_ws;
        case (s_phase)
            PH_OPEN, PH_FIRST, PH_KEYSTART, PH_COLON, PH_VALSTART, PH_AFTER: begin
                need_sp = 1'b1;
            end
            PH_NUM: begin
                if (!is_digit) begin
                    if (s_ovf || s_acc == '1) begin
                        err_hit = 1'b1;
                        err_code = E_NUM_BIG;
                    end else begin
                        need_sp = 1'b1;
                        ws_base = '0;
                        n_held = VT_NUMBER;
                        n_phase = PH_AFTER;
                    end
                end
            end
            default: ;
        endcase
        ws_inc = ws_base + 8'd1;

        if (need_sp) begin
            if (is_sp) begin
                n_ws = ws_inc;
                if (ws_inc >= ws_limit) begin
                    err_hit = 1'b1;
                    err_code = E_WHITESPACE;
                end
            end else begin
                n_ws = '0;
                if (b == 8'h00) begin
                    err_hit = 1'b1;
                    err_code = E_END;
                end else begin
                    go = 1'b1;
                end
            end
        end

        case (s_phase)
            PH_OPEN: begin
                if (go) begin
                    if (b == "{") n_phase = PH_FIRST;
                    else begin err_hit = 1'b1; err_code = E_NO_BRACE; end
                end
            end
            PH_FIRST, PH_KEYSTART: begin
                if (go) begin
                    if (s_phase == PH_FIRST && b == "}") begin
                        n_phase = PH_DONE;
                        res_has = 1'b1;
                        res_kind = K_EMPTY;
                    end else if (s_full) begin
                        err_hit = 1'b1; err_code = E_STORE_FULL;
                    end else if (b != "\"") begin
                        err_hit = 1'b1; err_code = E_KEY_QUOTE;
                    end else begin
                        n_start = s_next;
                        n_cur = CW'(s_next);
                        n_noroom = 1'b0;
                        n_phase = PH_KEY;
                    end
                end
            end
            PH_COLON: begin
                if (go) begin
                    if (b == ":") n_phase = PH_VALSTART;
                    else begin err_hit = 1'b1; err_code = E_COLON; end
                end
            end
            PH_VALSTART: begin
                if (go) begin
                    if (s_noroom) begin
                        err_hit = 1'b1; err_code = E_NO_ROOM;
                    end else if (b == "t" || b == "f" || b == "n") begin
                        n_lkind = (b == "t") ? LIT_TRUE : ((b == "f") ? LIT_FALSE : LIT_NULL);
                        n_lpos = '0;
                        n_phase = PH_LIT;
                    end else if (b == "[" || b == "{") begin
                        err_hit = 1'b1; err_code = E_NESTED;
                    end else if (b == "0") begin
                        n_held = VT_NUMBER;
                        n_acc = '0;
                        n_phase = PH_AFTER;
                    end else if (is_digit) begin
                        n_acc = {56'd0, b - 8'h30};
                        n_ovf = 1'b0;
                        n_phase = PH_NUM;
                    end else if (b == "\"") begin
                        if (s_full) begin
                            err_hit = 1'b1; err_code = E_STORE_FULL;
                        end else begin
                            n_start = s_next;
                            n_cur = CW'(s_next);
                            n_noroom = 1'b0;
                            n_phase = PH_STR;
                        end
                    end else begin
                        err_hit = 1'b1; err_code = E_VAL_START;
                    end
                end
            end
            PH_KEY, PH_STR: begin
                if (b == 8'h00) begin
                    err_hit = 1'b1; err_code = E_END;
                end else if (b == "\"") begin
                    if (s_phase == PH_STR && s_noroom) begin
                        err_hit = 1'b1; err_code = E_NO_ROOM;
                    end else begin
                        n_ws = '0;
                        if (s_phase == PH_KEY) begin
                            n_phase = PH_COLON;
                            n_key = s_start;
                        end else begin
                            n_phase = PH_AFTER;
                            n_held = VT_STRING;
                            n_acc = 64'(s_start);
                        end
                        // terminator
                        if (!s_noroom) begin
                            if (cur_inc >= STORE_SIZE) n_full = 1'b1;
                            else n_next = AW'(cur_inc);
                            res_has = 1'b1;
                            res_kind = K_WRITE;
                            wr_addr = s_cur;
                            wr_byte = 8'h00;
                        end
                    end
                end else if (s_noroom || s_cur >= STORE_LAST) begin
                    n_noroom = 1'b1;
                end else begin
                    n_cur = cur_inc;
                    res_has = 1'b1;
                    res_kind = K_WRITE;
                    wr_addr = s_cur;
                    wr_byte = b;
                end
            end
            PH_NUM: begin
                if (is_digit && !s_ovf) begin
                    if (acc_x10[67:64] != 4'd0) n_ovf = 1'b1;
                    else n_acc = acc_x10[63:0];
                end
            end
            PH_LIT: begin
                if (b != lit_exp) begin
                    err_hit = 1'b1; err_code = E_LITERAL;
                end else begin
                    n_lpos = lpos_inc;
                    if (lpos_inc >= lit_len(s_lkind)) begin
                        n_held = (s_lkind == LIT_TRUE || s_lkind == LIT_FALSE) ?
                                 VT_BOOL : VT_NULL;
                        n_acc = (s_lkind == LIT_TRUE) ? 64'd1 : 64'd0;
                        n_phase = PH_AFTER;
                        n_ws = '0;
                    end
                end
            end
            default: ;
        endcase

        // value finished: brace, comma or fault
        if (go && (s_phase == PH_AFTER || s_phase == PH_NUM)) begin
            if (b == "}") begin
                n_phase = PH_DONE;
                res_has = 1'b1;
                res_kind = K_MEMBER;
                mem_final = 1'b1;
            end else if (b == ",") begin
                n_count = MW'(cnt_inc);
                if (cnt_inc >= CNT_LIMIT) begin
                    err_hit = 1'b1; err_code = E_MEMBERS;
                end else begin
                    res_has = 1'b1;
                    res_kind = K_MEMBER;
                    n_phase = PH_KEYSTART;
                end
            end else begin
                err_hit = 1'b1; err_code = E_STRUCT;
            end
        end

        if (err_hit) begin
            n_phase = PH_ERR;
            res_has = 1'b1;
            res_kind = K_ERROR;
        end
    end

    // result fields
    always_comb begin
        n_kind = res_kind;
        n_addr = '0;  n_byte = '0;  n_midx = '0;  n_koff = '0;
        n_vtype = '0; n_val = '0;   n_final = 1'b0; n_ecode = '0;
        case (res_kind)
            K_WRITE: begin
                n_addr = 12'(wr_addr);
                n_byte = wr_byte;
            end
            K_MEMBER: begin
                n_midx = 6'(s_count);
                n_koff = 12'(s_key);
                n_vtype = n_held;
                n_val = n_acc;
                n_final = mem_final;
            end
            K_ERROR: begin
                n_midx = 6'(n_count);
                n_ecode = err_code;
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPEN; r_ws <= '0;   r_next <= '0;  r_full <= 1'b0;
            r_start <= '0;      r_cur <= '0;  r_noroom <= 1'b0;
            r_count <= '0;      r_key <= '0;  r_acc <= '0;   r_ovf <= 1'b0;
            r_held <= '0;       r_lpos <= '0; r_lkind <= '0;
        end else if (accept) begin
            r_phase <= n_phase; r_ws <= n_ws;   r_next <= n_next; r_full <= n_full;
            r_start <= n_start; r_cur <= n_cur; r_noroom <= n_noroom;
            r_count <= n_count; r_key <= n_key; r_acc <= n_acc;   r_ovf <= n_ovf;
            r_held <= n_held;   r_lpos <= n_lpos; r_lkind <= n_lkind;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= res_has;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_has) begin
            r_kind <= n_kind;   r_addr <= n_addr;   r_byte <= n_byte;
            r_midx <= n_midx;   r_koff <= n_koff;   r_vtype <= n_vtype;
            r_val <= n_val;     r_final <= n_final; r_ecode <= n_ecode;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.store_address = r_addr;
    assign o_out.store_byte    = r_byte;
    assign o_out.member_index  = r_midx;
    assign o_out.key_offset    = r_koff;
    assign o_out.val_type      = r_vtype;
    assign o_out.member_value  = r_val;
    assign o_out.is_final      = r_final;
    assign o_out.error_code    = r_ecode;

`ifndef SYNTHESIS
    // a finished or failed document stays silent until a new start
    a_silent_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_in.start_req && (r_phase == PH_DONE || r_phase == PH_ERR)
        |=> !r_out_valid)
        else $error("result after document end");

    // a pending error result always matches the error phase
    a_error_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == K_ERROR |-> r_phase == PH_ERR)
        else $error("error result without error phase");

    // string cursor never passes the last store position
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= STORE_LAST)
        else $error("store cursor out of range");

    // a result with no new transfer holds while the receiver stalls
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_kind))
        else $error("result dropped under stall");
`endif

endmodule

// File: test/fjp_checker.sv
`timescale 1ns / 100ps
module fjp_checker
    import fjp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fjp_in_if           in_mon,
    fjp_out_if          out_mon,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fails,
    output int          o_pending
);

    localparam int STORE_SIZE = DEF_CHAR_STORE_SIZE;
    localparam int MEMBER_MAX = DEF_MEMBER_LIMIT;
    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] store_address;
        logic [7:0]  store_byte;
        logic [5:0]  member_index;
        logic [11:0] key_offset;
        t_vtype      val_type;
        logic [63:0] member_value;
        logic        is_final;
        t_err        error_code;
    } t_result;

    t_result     pending_results[$];
    t_result     step_res;
    bit          step_has;

    // shadow of the parser state
    logic [7:0]  ws_limit;
    t_phase      ph;
    int unsigned ws_run;
    int unsigned store_next;
    bit          store_full;
    int unsigned str_start;
    int unsigned str_len;
    bit          str_no_room;
    int unsigned member_cnt;
    int unsigned key_start;
    logic [63:0] acc;
    bit          acc_ovf;
    t_vtype      held_type;
    int unsigned lit_pos;
    logic [1:0]  lit_kind;

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        o_fails++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    function automatic void clear_doc();
        ph = PH_OPEN;
        ws_run = 0;
        store_next = 0;
        store_full = 0;
        str_start = 0;
        str_len = 0;
        str_no_room = 0;
        member_cnt = 0;
        key_start = 0;
        acc = '0;
        acc_ovf = 0;
        held_type = VT_STRING;
        lit_pos = 0;
        lit_kind = LIT_TRUE;
    endfunction

    function automatic void emit_error(input t_err code);
        step_res = '0;
        step_res.kind = K_ERROR;
        step_res.member_index = member_cnt[5:0];
        step_res.error_code = code;
        step_has = 1;
        ph = PH_ERR;
    endfunction

    function automatic void emit_write(input int unsigned addr, input logic [7:0] b);
        step_res = '0;
        step_res.kind = K_WRITE;
        step_res.store_address = addr[11:0];
        step_res.store_byte = b;
        step_has = 1;
    endfunction

    function automatic void emit_member(input bit fin);
        step_res = '0;
        step_res.kind = K_MEMBER;
        step_res.member_index = member_cnt[5:0];
        step_res.key_offset = key_start[11:0];
        step_res.val_type = held_type;
        step_res.member_value = acc;
        step_res.is_final = fin;
        step_has = 1;
    endfunction

    // -1: byte not consumed by whitespace or end-of-text handling
    function automatic int ws_or_end(input logic [7:0] b);
        int unsigned lim;
        lim = (ws_limit == 0) ? 1 : ws_limit;
        if (b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
            ws_run++;
            if (ws_run >= lim) begin
                emit_error(E_WHITESPACE);
                return 1;
            end
            return 0;
        end
        ws_run = 0;
        if (b == 8'h00) begin
            emit_error(E_END);
            return 1;
        end
        return -1;
    endfunction

    function automatic void open_string(input t_phase nxt);
        str_start = store_next;
        str_len = 0;
        str_no_room = 0;
        ph = nxt;
    endfunction

    function automatic void string_char(input logic [7:0] b);
        int unsigned addr;
        addr = str_start + str_len;
        if (str_no_room || addr >= STORE_SIZE - 1) begin
            str_no_room = 1;
        end else begin
            str_len++;
            emit_write(addr, b);
        end
    endfunction

    function automatic void string_close();
        int unsigned addr;
        addr = str_start + str_len;
        if (!str_no_room) begin
            if (addr + 1 >= STORE_SIZE) store_full = 1;
            else store_next = addr + 1;
            emit_write(addr, 8'h00);
        end
    endfunction

    function automatic void key_open(input logic [7:0] b);
        if (store_full) emit_error(E_STORE_FULL);
        else if (b != "\"") emit_error(E_KEY_QUOTE);
        else open_string(PH_KEY);
    endfunction

    function automatic void after_value(input logic [7:0] b);
        if (ws_or_end(b) >= 0) return;
        if (b == "}") begin
            ph = PH_DONE;
            emit_member(1);
        end else if (b == ",") begin
            if (member_cnt + 1 >= MEMBER_MAX - 1) begin
                member_cnt++;
                emit_error(E_MEMBERS);
            end else begin
                emit_member(0);
                member_cnt++;
                ph = PH_KEYSTART;
            end
        end else begin
            emit_error(E_STRUCT);
        end
    endfunction

    function automatic void value_start(input logic [7:0] b);
        if (ws_or_end(b) >= 0) return;
        if (str_no_room) begin
            emit_error(E_NO_ROOM);
        end else if (b == "t" || b == "f" || b == "n") begin
            lit_kind = (b == "t") ? LIT_TRUE : ((b == "f") ? LIT_FALSE : LIT_NULL);
            lit_pos = 0;
            ph = PH_LIT;
        end else if (b == "[" || b == "{") begin
            emit_error(E_NESTED);
        end else if (b == "0") begin
            held_type = VT_NUMBER;
            acc = '0;
            ph = PH_AFTER;
        end else if (b >= "1" && b <= "9") begin
            acc = 64'(b - "0");
            acc_ovf = 0;
            ph = PH_NUM;
        end else if (b == "\"") begin
            if (store_full) emit_error(E_STORE_FULL);
            else open_string(PH_STR);
        end else begin
            emit_error(E_VAL_START);
        end
    endfunction

    // one accepted byte; leaves its result, if any, in step_res
    function automatic void parse_byte(input logic st, input logic [7:0] b);
        string       word;
        logic [63:0] d;
        step_has = 0;
        if (st) clear_doc();
        case (ph)
            PH_OPEN: begin
                if (ws_or_end(b) < 0) begin
                    if (b != "{") emit_error(E_NO_BRACE);
                    else ph = PH_FIRST;
                end
            end
            PH_FIRST: begin
                if (ws_or_end(b) < 0) begin
                    if (b == "}") begin
                        ph = PH_DONE;
                        step_res = '0;
                        step_res.kind = K_EMPTY;
                        step_has = 1;
                    end else begin
                        key_open(b);
                    end
                end
            end
            PH_KEYSTART: begin
                if (ws_or_end(b) < 0) key_open(b);
            end
            PH_KEY: begin
                if (b == 8'h00) begin
                    emit_error(E_END);
                end else if (b == "\"") begin
                    ph = PH_COLON;
                    ws_run = 0;
                    key_start = str_start;
                    string_close();
                end else begin
                    string_char(b);
                end
            end
            PH_COLON: begin
                if (ws_or_end(b) < 0) begin
                    if (b != ":") emit_error(E_COLON);
                    else ph = PH_VALSTART;
                end
            end
            PH_VALSTART: value_start(b);
            PH_STR: begin
                if (b == 8'h00) begin
                    emit_error(E_END);
                end else if (b == "\"") begin
                    if (str_no_room) begin
                        emit_error(E_NO_ROOM);
                    end else begin
                        held_type = VT_STRING;
                        acc = 64'(str_start);
                        ph = PH_AFTER;
                        ws_run = 0;
                        string_close();
                    end
                end else begin
                    string_char(b);
                end
            end
            PH_NUM: begin
                if (b >= "0" && b <= "9") begin
                    d = 64'(b - "0");
                    if (!acc_ovf) begin
                        if (acc > (U64_MAX - d) / 10) acc_ovf = 1;
                        else acc = acc * 10 + d;
                    end
                end else if (acc_ovf || acc == U64_MAX) begin
                    emit_error(E_NUM_BIG);
                end else begin
                    held_type = VT_NUMBER;
                    ph = PH_AFTER;
                    ws_run = 0;
                    after_value(b);
                end
            end
            PH_LIT: begin
                word = (lit_kind == LIT_TRUE) ? "rue" : ((lit_kind == LIT_FALSE) ? "alse" : "ull");
                if (b != word[lit_pos]) begin
                    emit_error(E_LITERAL);
                end else begin
                    lit_pos++;
                    if (lit_pos >= word.len()) begin
                        held_type = (lit_kind == LIT_NULL) ? VT_NULL : VT_BOOL;
                        acc = (lit_kind == LIT_TRUE) ? 64'd1 : 64'd0;
                        ph = PH_AFTER;
                        ws_run = 0;
                    end
                end
            end
            PH_AFTER: after_value(b);
            default: ;
        endcase
    endfunction

    // config writes, result compare, then prediction for the input transfer
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            o_fails = 0;
            ws_limit = DEF_MAX_WS_RUN;
            clear_doc();
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_ADDR_WS[2])
                ws_limit = i_pwdata[7:0];
            if (out_mon.valid && out_mon.ready) begin
                got = '{t_kind'(out_mon.kind), out_mon.store_address, out_mon.store_byte,
                        out_mon.member_index, out_mon.key_offset,
                        t_vtype'(out_mon.val_type), out_mon.member_value,
                        out_mon.is_final, t_err'(out_mon.error_code)};
                if (pending_results.size() == 0) begin
                    report($sformatf("unexpected result kind %0d", got.kind));
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", got.kind, want.kind);
                    check_field("store_address", got.store_address, want.store_address);
                    check_field("store_byte", got.store_byte, want.store_byte);
                    check_field("member_index", got.member_index, want.member_index);
                    check_field("key_offset", got.key_offset, want.key_offset);
                    check_field("val_type", got.val_type, want.val_type);
                    check_field("member_value", got.member_value, want.member_value);
                    check_field("is_final", got.is_final, want.is_final);
                    check_field("error_code", got.error_code, want.error_code);
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                parse_byte(in_mon.start_req, in_mon.text_byte);
                if (step_has) pending_results.push_back(step_res);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
module tb;
    import fjp_pkg::*;

    localparam int STALL_LIMIT = 10000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fails;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int stall_cycles = 0;
    int bytes_sent = 0;

    logic [7:0] doc_bytes[$];

    fjp_in_if  in_ch();
    fjp_out_if out_ch();

    flat_json_object_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fjp_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_fails   (fails),
        .o_pending (pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end

    // no transfer on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic st, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 0;
            @(negedge i_clk);
        end
        in_ch.valid = 1;
        in_ch.start_req = st;
        in_ch.text_byte = b;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 0;
        bytes_sent++;
    endtask

    task automatic send_doc();
        foreach (doc_bytes[i]) send_byte(i == 0, doc_bytes[i]);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
    endtask

    task automatic add_ws();
        int n;
        logic [7:0] spaces[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
        n = ($urandom_range(3) == 0) ? $urandom_range(4) : 0;
        repeat (n) doc_bytes.push_back(spaces[$urandom_range(3)]);
    endtask

    // quoted string of random characters, never a quote or a zero
    task automatic add_string(input int len);
        logic [7:0] c;
        doc_bytes.push_back("\"");
        repeat (len) begin
            if ($urandom_range(4) == 0) c = 8'($urandom_range(1, 255));
            else c = 8'($urandom_range(8'h23, 8'h7E));
            if (c == "\"") c = "#";
            doc_bytes.push_back(c);
        end
        doc_bytes.push_back("\"");
    endtask

    task automatic add_value();
        case ($urandom_range(7))
            0, 1: add_string($urandom_range(6));
            2: add_text("true");
            3: add_text("false");
            4: add_text("null");
            5: add_text("0");
            6: add_text($sformatf("%0d", $urandom_range(1, 999)));
            default: begin
                case ($urandom_range(3))
                    0: add_text("18446744073709551614");
                    1: add_text("18446744073709551615");
                    2: add_text("99999999999999999999");
                    default: add_text($sformatf("%0d", {$urandom, $urandom} | 64'd1));
                endcase
            end
        endcase
    endtask

    // object with n members, optionally damaged afterwards
    task automatic make_doc(input int n, input bit damage);
        int pos;
        string pool;
        doc_bytes.delete();
        pool = "[{,:\"tfn0 ";
        add_ws();
        doc_bytes.push_back("{");
        add_ws();
        if (n == 0) doc_bytes.push_back("}");
        for (int m = 0; m < n; m++) begin
            add_ws();
            add_string($urandom_range(5));
            add_ws();
            doc_bytes.push_back(":");
            add_ws();
            add_value();
            add_ws();
            doc_bytes.push_back((m == n - 1) ? "}" : ",");
        end
        if (damage) begin
            pos = $urandom_range(doc_bytes.size() - 1);
            case ($urandom_range(3))
                0: doc_bytes[pos] = 8'($urandom_range(255));
                1: begin
                    while (doc_bytes.size() > pos) void'(doc_bytes.pop_back());
                    doc_bytes.push_back(8'h00);
                end
                2: doc_bytes.insert(pos, pool[$urandom_range(9)]);
                default: doc_bytes[pos] = 8'h00;
            endcase
        end
        // bytes after the end are ignored until the next start
        if ($urandom_range(7) == 0) doc_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_ws_limit(input logic [7:0] v);
        wait_idle();
        psel = 1;
        pwrite = 1;
        paddr = REG_ADDR_WS[2:0];
        pwdata = {24'd0, v};
        penable = 0;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic send_text(input string s);
        doc_bytes.delete();
        add_text(s);
        send_doc();
    endtask

    initial begin
        logic [7:0] limits[5] = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd8};
        int target;
        in_ch.valid = 0;
        in_ch.start_req = 0;
        in_ch.text_byte = '0;
        tx_idle_pct = 29;
        rx_idle_pct = 49;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty object, all value kinds, bad openings
        send_text("{}");
        send_text("{\"k\":\"v\",\"n\":18446744073709551614,\"t\":true,\"f\":false,\"z\":null}");
        send_text("x");
        doc_bytes.delete();
        add_text("{");
        doc_bytes.push_back(8'h00);
        send_doc();

        // random documents under several whitespace limits and idle mixes
        foreach (limits[s]) begin
            if (s == 2) begin
                tx_idle_pct = 49;
                rx_idle_pct = 29;
            end else if (s == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_ws_limit(limits[s]);
            target = bytes_sent + 110;
            while (bytes_sent < target) begin
                make_doc(($urandom_range(15) == 0) ? 0 : $urandom_range(1, 5),
                         $urandom_range(99) < 30);
                send_doc();
            end
        end

        // member limit: short members until the comma count runs out
        doc_bytes.delete();
        add_text("{");
        for (int m = 0; m < DEF_MEMBER_LIMIT; m++) add_text("\"k\":0,");
        add_text("\"k\":0}");
        send_doc();

        in_ch.valid = 0;
        wait_idle();
        repeat (20) @(negedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/fjp_pkg.sv
hw/rtl/fjp_if.sv
hw/rtl/flat_json_object_parser.sv
test/fjp_checker.sv
test/tb.sv
